>>> src/ostt_pkg.sv
// shared types, codes and defaults for the one-shot timeout table
// no dependencies; every other file but ostt_fifo imports this package
package ostt_pkg;

	localparam int unsigned SLOTS_DEF = 16;

	// operation codes carried by the func field
	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_SET     = 2'd1,
		OP_QUERY   = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_PASSED = 2'd1,
		ST_UNUSED = 2'd2,
		ST_ERROR  = 2'd3
	} status_t;

	// per-slot flag bits
	localparam int unsigned FL_USED   = 0;
	localparam int unsigned FL_ARMED  = 1;
	localparam int unsigned FL_PASSED = 2;
	localparam logic [2:0] FLAGS_LIVE = 3'b011;

	typedef struct packed {
		logic [1:0]  func;
		logic [30:0] delay;
		logic [3:0]  slot;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  slot_out;
		logic [30:0] next_wait;
	} result_t;

	// classified command handed from front to back
	typedef struct packed {
		op_t         op;
		logic [30:0] delay;
		logic [3:0]  slot;
		logic        slot_ok;
		logic        delay_ok;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_SCAN = 2'd1,
		BK_FIN  = 2'd2
	} back_state_t;

endpackage

>>> src/ostt_fifo.sv
// two-entry queue of raw words, used between front and back and at the output
// depends on nothing but its width parameter
module ostt_fifo #(
	parameter int unsigned W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= wdata;
	end

endmodule

>>> src/ostt_front.sv
// front part: takes input transactions, classifies them and queues commands
// depends on ostt_pkg and ostt_fifo
module ostt_front import ostt_pkg::*; #(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t item,
	output logic  full,
	input  logic  cmd_pop,
	output cmd_t  cmd,
	output logic  cmd_empty
);

	cmd_t cls;
	logic [$bits(cmd_t)-1:0] cmd_raw;

	// decode operation, range check the slot, flag a zero delay
	always_comb begin
		cls.op       = op_t'(item.func);
		cls.delay    = item.delay;
		cls.slot     = item.slot;
		cls.slot_ok  = (32'(item.slot) < SLOTS);
		cls.delay_ok = (item.delay != '0);
	end

	ostt_fifo #(.W($bits(cmd_t))) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cls),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd_raw),
		.empty (cmd_empty)
	);

	assign cmd = cmd_t'(cmd_raw);

endmodule

>>> src/ostt_back.sv
// back part: executes commands against the flag table and deadline memory
// depends on ostt_pkg; feeds the result queue in the top level
module ostt_back import ostt_pkg::*; #(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  logic    cmd_empty,
	output logic    cmd_pop,
	output logic    res_push,
	output result_t res,
	input  logic    res_full
);

	localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CW = $clog2(SLOTS + 1);
	localparam logic [CW-1:0] LAST = CW'(SLOTS);

	back_state_t state_q, state_d;

	cmd_t          cmd_q;
	logic [31:0]   time_q;
	logic [2:0]    flags_q [SLOTS];
	logic [31:0]   dl_mem [SLOTS];
	logic [31:0]   dl_s1;
	logic          ev_v_s1;
	logic [IW-1:0] ev_idx_s1;
	logic [CW-1:0] cnt_q;
	logic [30:0]   nwait_q;
	logic          found_v_q;
	logic [IW-1:0] found_q;

	logic          direct;
	logic [IW-1:0] fidx;
	logic [2:0]    f;
	logic          pend;
	logic [31:0]   d;
	logic          start;
	logic          fin_go;

	// query and release are answered directly from idle; tick and set run a scan
	assign direct = (cmd.op == OP_QUERY) || (cmd.op == OP_RELEASE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!cmd_empty && !direct) state_d = BK_SCAN;
			end
			BK_SCAN: begin
				if (cnt_q == LAST) state_d = BK_FIN;
			end
			BK_FIN: begin
				if (!res_full) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// flag read port: command slot when idle, evaluated slot while scanning
	assign fidx = (state_q == BK_IDLE) ? IW'(cmd.slot) : ev_idx_s1;
	assign f    = flags_q[fidx];
	assign pend = (f == FLAGS_LIVE);
	assign d    = dl_s1 - time_q;

	always_comb begin
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		res      = '0;
		unique case (state_q)
			BK_IDLE: begin
				cmd_pop      = !cmd_empty && (!direct || !res_full);
				res_push     = !cmd_empty && direct && !res_full;
				res.slot_out = cmd.slot;
				if (!cmd.slot_ok) res.status = ST_UNUSED;
				else if ((f & FLAGS_LIVE) != FLAGS_LIVE) res.status = ST_UNUSED;
				else if (f[FL_PASSED]) res.status = ST_PASSED;
				else res.status = ST_OK;
			end
			BK_FIN: begin
				res_push = !res_full;
				if (cmd_q.op == OP_TICK) begin
					res.status    = ST_OK;
					res.slot_out  = cmd_q.slot;
					res.next_wait = nwait_q;
				end else if (found_v_q) begin
					res.status    = ST_OK;
					res.slot_out  = 4'(found_q);
					res.next_wait = nwait_q;
				end else begin
					res.status    = ST_ERROR;
					res.slot_out  = cmd_q.slot;
				end
			end
			default: ;
		endcase
	end

	assign start  = (state_q == BK_IDLE) && cmd_pop && !direct;
	assign fin_go = (state_q == BK_FIN) && !res_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			time_q    <= '0;
			ev_v_s1   <= 1'b0;
			cnt_q     <= '0;
			found_v_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) flags_q[i] <= '0;
		end else begin
			state_q <= state_d;
			ev_v_s1 <= (state_q == BK_SCAN) && (cnt_q != LAST);
			if (start) begin
				cnt_q     <= '0;
				found_v_q <= 1'b0;
				if (cmd.op == OP_TICK) time_q <= time_q + 32'd1;
			end
			if ((state_q == BK_SCAN) && (cnt_q != LAST)) cnt_q <= cnt_q + CW'(1);
			// release keeps only the passed mark
			if ((state_q == BK_IDLE) && cmd_pop && (cmd.op == OP_RELEASE) && cmd.slot_ok)
				flags_q[fidx] <= f & (3'b1 << FL_PASSED);
			if (ev_v_s1) begin
				if (cmd_q.op == OP_TICK) begin
					if (pend && ((d == '0) || d[31])) flags_q[ev_idx_s1][FL_PASSED] <= 1'b1;
				end else if (!f[FL_USED] && !found_v_q && cmd_q.delay_ok) begin
					found_v_q <= 1'b1;
				end
			end
			if (fin_go && (cmd_q.op == OP_SET) && found_v_q) flags_q[found_q] <= FLAGS_LIVE;
		end
	end

	// payload side of the scan: shortest wait and first free slot
	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q   <= cmd;
			nwait_q <= (cmd.op == OP_SET) ? cmd.delay : '0;
		end
		if (ev_v_s1) begin
			if (cmd_q.op == OP_TICK) begin
				if (pend && (d != '0) && !d[31] &&
				    ((nwait_q == '0) || (d[30:0] < nwait_q)))
					nwait_q <= d[30:0];
			end else begin
				if (pend && !d[31] && (d[30:0] < nwait_q)) nwait_q <= d[30:0];
				if (!f[FL_USED] && !found_v_q) found_q <= ev_idx_s1;
			end
		end
	end

	// deadline memory: one registered read a cycle during the scan, one write on set
	always_ff @(posedge clk) begin
		if ((state_q == BK_SCAN) && (cnt_q != LAST)) begin
			dl_s1     <= dl_mem[cnt_q[IW-1:0]];
			ev_idx_s1 <= cnt_q[IW-1:0];
		end
		if (fin_go && (cmd_q.op == OP_SET) && found_v_q)
			dl_mem[found_q] <= time_q + {1'b0, cmd_q.delay};
	end

endmodule

>>> src/one_shot_timeout_table.sv
// top level of the one-shot timeout table: front, back and result queue
// depends on ostt_pkg, ostt_fifo, ostt_front and ostt_back
//
// A table of SLOTS one-shot timeouts on one 32-bit time base that advances
// by one on each tick. Each input transaction carries func (tick, set, query,
// release), delay and slot, and gives exactly one result transaction with
// status, slot_out and next_wait. Tick and set walk the deadline memory one
// slot per cycle in the back part; query and release are answered directly
// from the idle state without a scan. The deadline memory has a single read
// port, which is what sets the scan length. Deadlines compare through the
// signed difference to the current time, so the time base may wrap. A
// two-entry command queue decouples input from execution and a two-entry
// result queue decouples execution from the consumer; there is no clearing
// pass after reset, the slot flags clear at once.
module one_shot_timeout_table import ostt_pkg::*; #(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	// input transactions
	input  logic    push,
	input  item_t   item,
	output logic    full,
	// result transactions
	input  logic    pop,
	output result_t result,
	output logic    empty
);

	cmd_t    cmd;
	logic    cmd_empty;
	logic    cmd_pop;
	logic    res_push;
	result_t res;
	logic    res_full;
	logic [$bits(result_t)-1:0] res_raw;

	// front: classify and queue commands
	ostt_front #(.SLOTS(SLOTS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.cmd_empty(cmd_empty)
	);

	// back: flag table, deadline memory and time base
	ostt_back #(.SLOTS(SLOTS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full)
	);

	// results wait here until the consumer pops them
	ostt_fifo #(.W($bits(result_t))) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_raw),
		.empty (empty)
	);

	assign result = result_t'(res_raw);

endmodule
